### hw/rtl/bounded_deque_with_sort_top_defines.svh
// Assertion helpers used by the top-level RTL file
`ifndef BOUNDED_DEQUE_WITH_SORT_TOP_DEFINES_SVH
`define BOUNDED_DEQUE_WITH_SORT_TOP_DEFINES_SVH

// check on every rising clk edge outside reset
`define BDQ_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// check on every rising clk edge, reset included
`define BDQ_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

### hw/rtl/bdq_pkg.sv
`default_nettype none
package bdq_pkg;

  localparam int CAPACITY = 16;
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int IDX_W    = $clog2(CAPACITY);
  localparam int PASS_W   = $clog2(CAPACITY);
  localparam int DATA_W   = 32;
  localparam int POS_W    = 5;
  localparam int ENTRY_W  = 5;
  localparam int CMP_W    = (CNT_W > POS_W) ? CNT_W : POS_W;

  localparam logic [2:0] REQ_PUSH_BACK  = 3'd0;
  localparam logic [2:0] REQ_PUSH_FRONT = 3'd1;
  localparam logic [2:0] REQ_POP_BACK   = 3'd2;
  localparam logic [2:0] REQ_POP_FRONT  = 3'd3;
  localparam logic [2:0] REQ_INSERT     = 3'd4;
  localparam logic [2:0] REQ_FIND       = 3'd5;
  localparam logic [2:0] REQ_READ       = 3'd6;
  localparam logic [2:0] REQ_SORT       = 3'd7;

  localparam logic [1:0] STAT_OK    = 2'd0;
  localparam logic [1:0] STAT_EMPTY = 2'd1;
  localparam logic [1:0] STAT_FULL  = 2'd2;
  localparam logic [1:0] STAT_RANGE = 2'd3;

  localparam logic [1:0] CELL_HOLD   = 2'd0;
  localparam logic [1:0] CELL_INSERT = 2'd1;
  localparam logic [1:0] CELL_POPF   = 2'd2;
  localparam logic [1:0] CELL_SORT   = 2'd3;

  localparam logic signed [DATA_W-1:0] ERR_VALUE = '1;

  typedef struct packed {
    logic [2:0]               req_type;
    logic signed [DATA_W-1:0] data_value;
    logic [POS_W-1:0]         position;
  } bdq_in_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] result_value;
    logic                     found;
    logic [1:0]               status;
    logic [ENTRY_W-1:0]       entry_count;
  } bdq_out_t;

  typedef struct packed {
    logic [1:0]               op;
    logic [CNT_W-1:0]         pos;
    logic [CNT_W-1:0]         cnt;
    logic signed [DATA_W-1:0] value;
    logic                     phase;
  } bdq_cell_cmd_t;

endpackage
`default_nettype wire

### hw/rtl/bounded_deque_with_sort_top.sv
// Bounded double-ended queue of signed 32-bit values with in-place sort.
// Input channel in_valid/in_ready/in_data carries one request per
// transaction (push/pop at either end, insert, find, read, sort); the
// output channel out_valid/out_ready/out_data returns exactly one result
// transaction per request, in request order.
// Storage is a row of CAPACITY cells; each cell holds one entry and takes
// its neighbor's value when entries shift or swap.
// Push, pop, insert, find and read: result valid the cycle after the
// request is taken; one request per cycle while the result is taken.
// Sort: odd-even transposition, CAPACITY passes, one pass per cycle
// through the cell row; in_ready stays low from the request until the
// result appears.
// A stalled out_ready holds the result register; a new request is taken in
// the same cycle the waiting result leaves.
// Reset (rst_n low, synchronous) empties the queue and drops any pending
// result; entry contents are left as they are and are never read before
// being written.
`default_nettype none
`include "bounded_deque_with_sort_top_defines.svh"
module bounded_deque_with_sort_top
  import bdq_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  output logic          in_ready,
  input  wire bdq_in_t  in_data,
  output logic          out_valid,
  input  wire logic     out_ready,
  output bdq_out_t      out_data
);

  localparam logic S_IDLE = 1'b0;
  localparam logic S_SORT = 1'b1;

  logic                     state_r, state_nxt;
  logic [PASS_W-1:0]        pass_r, pass_nxt;
  logic [CNT_W-1:0]         count_r, count_nxt;
  logic                     out_valid_r, out_valid_nxt;
  bdq_out_t                 out_data_r, out_data_nxt;

  logic                     accept;
  logic                     full;
  logic                     empty;
  logic                     sort_last;
  logic [CMP_W-1:0]         pos_c;
  logic [CMP_W-1:0]         cnt_c;
  logic [CNT_W-1:0]         cnt_m1;
  logic [IDX_W-1:0]         rd_idx;
  logic signed [DATA_W-1:0] rd_val;
  logic signed [DATA_W-1:0] res;
  logic                     fnd;
  logic [1:0]               st;
  logic                     load_out;
  bdq_cell_cmd_t            cmd;

  logic signed [DATA_W-1:0] cell_val [CAPACITY];
  logic [CAPACITY-1:0]      cell_match;

  genvar gi;
  generate
    for (gi = 0; gi < CAPACITY; gi++) begin : g_cell
      logic signed [DATA_W-1:0] left_v;
      logic signed [DATA_W-1:0] right_v;
      if (gi == 0) begin : g_first
        assign left_v = cell_val[gi];
      end else begin : g_left
        assign left_v = cell_val[gi-1];
      end
      if (gi == CAPACITY - 1) begin : g_last
        assign right_v = cell_val[gi];
      end else begin : g_right
        assign right_v = cell_val[gi+1];
      end
      bdq_cell u_cell (
        .clk       (clk),
        .idx       (CNT_W'(gi)),
        .cmd       (cmd),
        .left_val  (left_v),
        .right_val (right_v),
        .val       (cell_val[gi]),
        .match     (cell_match[gi])
      );
    end
  endgenerate

  assign in_ready  = (state_r == S_IDLE) && (!out_valid_r || out_ready);
  assign accept    = in_valid && in_ready;
  assign full      = (count_r == CNT_W'(CAPACITY));
  assign empty     = (count_r == '0);
  assign sort_last = (state_r == S_SORT) && (pass_r == PASS_W'(CAPACITY - 1));
  assign pos_c     = CMP_W'(in_data.position);
  assign cnt_c     = CMP_W'(count_r);
  assign cnt_m1    = count_r - CNT_W'(1);

  always_comb begin
    unique case (in_data.req_type)
      REQ_POP_BACK:  rd_idx = cnt_m1[IDX_W-1:0];
      REQ_POP_FRONT: rd_idx = '0;
      default:       rd_idx = pos_c[IDX_W-1:0];
    endcase
  end

  assign rd_val = cell_val[rd_idx];

  always_comb begin
    state_nxt     = state_r;
    pass_nxt      = pass_r;
    count_nxt     = count_r;
    res           = '0;
    fnd           = 1'b0;
    st            = STAT_OK;
    load_out      = 1'b0;
    cmd.op        = CELL_HOLD;
    cmd.pos       = pos_c[CNT_W-1:0];
    cmd.cnt       = count_r;
    cmd.value     = in_data.data_value;
    cmd.phase     = pass_r[0];

    if (state_r == S_SORT) begin
      cmd.op   = CELL_SORT;
      pass_nxt = pass_r + PASS_W'(1);
      if (sort_last) begin
        state_nxt = S_IDLE;
        load_out  = 1'b1;
      end
    end else if (accept) begin
      load_out = 1'b1;
      unique case (in_data.req_type)
        REQ_PUSH_BACK, REQ_PUSH_FRONT: begin
          if (full) begin
            st = STAT_FULL;
          end else begin
            cmd.op    = CELL_INSERT;
            cmd.pos   = (in_data.req_type == REQ_PUSH_BACK) ? count_r : '0;
            count_nxt = count_r + CNT_W'(1);
          end
        end
        REQ_POP_BACK, REQ_POP_FRONT: begin
          if (empty) begin
            st = STAT_EMPTY;
          end else begin
            res       = rd_val;
            count_nxt = cnt_m1;
            if (in_data.req_type == REQ_POP_FRONT) begin
              cmd.op = CELL_POPF;
            end
          end
        end
        REQ_INSERT: begin
          if (full) begin
            st = STAT_FULL;
          end else if (pos_c > cnt_c) begin
            st = STAT_RANGE;
          end else begin
            cmd.op    = CELL_INSERT;
            count_nxt = count_r + CNT_W'(1);
          end
        end
        REQ_FIND: fnd = |cell_match;
        REQ_READ: begin
          if (empty) begin
            st = STAT_EMPTY;
          end else if (pos_c >= cnt_c) begin
            st = STAT_RANGE;
          end else begin
            res = rd_val;
          end
        end
        REQ_SORT: begin
          load_out  = 1'b0;
          state_nxt = S_SORT;
          pass_nxt  = '0;
        end
        default: load_out = 1'b1;
      endcase
    end

    if (st != STAT_OK) begin
      res = ERR_VALUE;
    end

    out_data_nxt.result_value = res;
    out_data_nxt.found        = fnd;
    out_data_nxt.status       = st;
    out_data_nxt.entry_count  = ENTRY_W'(count_nxt);

    if (load_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      pass_r      <= '0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      pass_r      <= pass_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  `BDQ_ASSERT_ALWAYS(a_count_bound, !rst_n || count_r <= CNT_W'(CAPACITY), "count above capacity")
  `BDQ_ASSERT(a_no_accept_in_sort, (state_r == S_SORT) |-> !in_ready, "request taken during sort")
  `BDQ_ASSERT(a_result_follows, accept && in_data.req_type != REQ_SORT |=> out_valid_r, "no result")
  `BDQ_ASSERT(a_sort_done, sort_last |=> (out_valid_r && state_r == S_IDLE), "sort did not finish")
  `BDQ_ASSERT(a_count_hold, !accept |=> $stable(count_r), "count moved without a request")

endmodule
`default_nettype wire

### hw/rtl/bdq_cell.sv
`default_nettype none
module bdq_cell
  import bdq_pkg::*;
(
  input  wire logic                     clk,
  input  wire logic [CNT_W-1:0]         idx,
  input  wire bdq_cell_cmd_t            cmd,
  input  wire logic signed [DATA_W-1:0] left_val,
  input  wire logic signed [DATA_W-1:0] right_val,
  output logic signed [DATA_W-1:0]      val,
  output logic                          match
);

  logic signed [DATA_W-1:0] val_r;
  logic signed [DATA_W-1:0] val_nxt;
  logic [CNT_W-1:0]         idx_p1;
  logic                     in_use;
  logic                     swap_r;
  logic                     swap_l;

  assign idx_p1 = idx + CNT_W'(1);
  assign in_use = (idx < cmd.cnt);
  assign swap_r = (idx[0] == cmd.phase) && (idx_p1 < cmd.cnt) && (right_val < val_r);
  assign swap_l = (idx[0] != cmd.phase) && (idx != '0) && in_use && (val_r < left_val);

  always_comb begin
    val_nxt = val_r;
    unique case (cmd.op)
      CELL_HOLD: val_nxt = val_r;
      CELL_INSERT: begin
        if (idx > cmd.pos) begin
          val_nxt = left_val;
        end else if (idx == cmd.pos) begin
          val_nxt = cmd.value;
        end
      end
      CELL_POPF: val_nxt = right_val;
      CELL_SORT: begin
        if (swap_r) begin
          val_nxt = right_val;
        end else if (swap_l) begin
          val_nxt = left_val;
        end
      end
      default: val_nxt = val_r;
    endcase
  end

  always_ff @(posedge clk) begin
    val_r <= val_nxt;
  end

  assign val   = val_r;
  assign match = in_use && (val_r == cmd.value);

endmodule
`default_nettype wire

### tb/sv/tb_bounded_deque_with_sort_top.sv
import bdq_pkg::*;

class deque_scoreboard;
  logic signed [DATA_W-1:0] slots[CAPACITY];
  int depth;
  int mismatches;
  bdq_out_t pending_results[$];

  function new();
    depth = 0;
    mismatches = 0;
  endfunction

  function void note_request(bdq_in_t req);
    bdq_out_t res;
    logic signed [DATA_W-1:0] tmp;
    int i;
    int j;
    int at;
    res = '0;
    res.status = STAT_OK;
    case (req.req_type)
      REQ_PUSH_BACK, REQ_PUSH_FRONT, REQ_INSERT: begin
        if (depth >= CAPACITY) begin
          res.status = STAT_FULL;
        end else if (req.req_type == REQ_INSERT && int'(req.position) > depth) begin
          res.status = STAT_RANGE;
        end else begin
          if (req.req_type == REQ_PUSH_BACK) at = depth;
          else if (req.req_type == REQ_PUSH_FRONT) at = 0;
          else at = int'(req.position);
          for (i = depth; i > at; i--) slots[i] = slots[i - 1];
          slots[at] = req.data_value;
          depth++;
        end
      end
      REQ_POP_BACK, REQ_POP_FRONT: begin
        if (depth == 0) begin
          res.status = STAT_EMPTY;
        end else begin
          at = (req.req_type == REQ_POP_BACK) ? depth - 1 : 0;
          res.result_value = slots[at];
          for (i = at; i + 1 < depth; i++) slots[i] = slots[i + 1];
          depth--;
        end
      end
      REQ_FIND: begin
        for (i = 0; i < depth; i++)
          if (slots[i] == req.data_value) res.found = 1'b1;
      end
      REQ_READ: begin
        if (depth == 0) res.status = STAT_EMPTY;
        else if (int'(req.position) >= depth) res.status = STAT_RANGE;
        else res.result_value = slots[req.position];
      end
      default: begin
        for (i = 1; i < depth; i++) begin
          j = i;
          while (j > 0 && slots[j] < slots[j - 1]) begin
            tmp = slots[j];
            slots[j] = slots[j - 1];
            slots[j - 1] = tmp;
            j--;
          end
        end
      end
    endcase
    if (res.status != STAT_OK) res.result_value = ERR_VALUE;
    res.entry_count = ENTRY_W'(depth);
    pending_results.insert(pending_results.size(), res);
  endfunction

  function void check_result(bdq_out_t got);
    bdq_out_t want;
    if (pending_results.size() == 0) begin
      mismatches++;
      if (mismatches <= 20)
        $display("%0t: unexpected transaction, expected none, %s",
                 $time,
                 $sformatf("actual value=%0d found=%0b status=%0d count=%0d",
                           got.result_value, got.found, got.status, got.entry_count));
      return;
    end
    want = pending_results[0];
    pending_results.delete(0);
    if (got.result_value !== want.result_value || got.found !== want.found ||
        got.status !== want.status || got.entry_count !== want.entry_count) begin
      mismatches++;
      if (mismatches <= 20)
        $display("%0t: mismatch, %s, %s", $time,
                 $sformatf("expected value=%0d found=%0b status=%0d count=%0d",
                           want.result_value, want.found, want.status, want.entry_count),
                 $sformatf("actual value=%0d found=%0b status=%0d count=%0d",
                           got.result_value, got.found, got.status, got.entry_count));
    end
  endfunction
endclass

module tb_bounded_deque_with_sort_top;
  logic clk = 1'b0;
  logic rst_n;
  logic in_valid;
  logic in_ready;
  bdq_in_t in_data;
  logic out_valid;
  logic out_ready;
  bdq_out_t out_data;

  deque_scoreboard sb;
  int in_idle_pct;
  int out_idle_pct;
  int hold_len;

  bounded_deque_with_sort_top u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic bdq_in_t make_req(logic [2:0] kind, logic signed [DATA_W-1:0] v,
                                       logic [POS_W-1:0] p);
    bdq_in_t req;
    req.req_type = kind;
    req.data_value = v;
    req.position = p;
    return req;
  endfunction

  function automatic logic signed [DATA_W-1:0] pick_value();
    case ($urandom_range(3))
      0: return $urandom;
      1: begin
        case ($urandom_range(3))
          0: return 32'sh7fffffff;
          1: return 32'sh80000000;
          2: return -1;
          default: return 0;
        endcase
      end
      default: return int'($urandom_range(8)) - 4;
    endcase
  endfunction

  function automatic bdq_in_t random_request(bit grow);
    int r;
    logic [2:0] kind;
    logic [POS_W-1:0] p;
    r = $urandom_range(99);
    if (grow) begin
      if (r < 25) kind = REQ_PUSH_BACK;
      else if (r < 45) kind = REQ_PUSH_FRONT;
      else if (r < 62) kind = REQ_INSERT;
      else if (r < 68) kind = REQ_POP_BACK;
      else if (r < 74) kind = REQ_POP_FRONT;
      else if (r < 84) kind = REQ_FIND;
      else if (r < 95) kind = REQ_READ;
      else kind = REQ_SORT;
    end else begin
      if (r < 8) kind = REQ_PUSH_BACK;
      else if (r < 14) kind = REQ_PUSH_FRONT;
      else if (r < 20) kind = REQ_INSERT;
      else if (r < 45) kind = REQ_POP_BACK;
      else if (r < 70) kind = REQ_POP_FRONT;
      else if (r < 80) kind = REQ_FIND;
      else if (r < 93) kind = REQ_READ;
      else kind = REQ_SORT;
    end
    if ($urandom_range(4) == 0) p = POS_W'($urandom_range(31));
    else p = POS_W'($urandom_range(sb.depth + 1));
    return make_req(kind, pick_value(), p);
  endfunction

  task automatic send_request(input bdq_in_t req);
    while ($urandom_range(99) < in_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= req;
    do @(posedge clk); while (!in_ready);
    sb.note_request(req);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (sb.pending_results.size() != 0);
  endtask

  task automatic random_phase(input int n);
    bit grow;
    grow = 1'b1;
    for (int k = 0; k < n; k++) begin
      if ($urandom_range(39) == 0) grow = !grow;
      send_request(random_request(grow));
    end
  endtask

  initial begin
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && out_ready) sb.check_result(out_data);
      if (hold_len > 0) begin
        hold_len--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(99) >= out_idle_pct);
      end
    end
  end

  initial begin
    #3200000;
    $display("TB_ERROR");
    $finish;
  end

  initial begin
    sb = new();
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    out_ready = 1'b0;
    in_idle_pct = 18;
    out_idle_pct = 88;
    hold_len = 0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_request(make_req(REQ_POP_BACK, 0, 0));
    send_request(make_req(REQ_POP_FRONT, 0, 0));
    send_request(make_req(REQ_READ, 0, 0));
    send_request(make_req(REQ_FIND, 0, 0));
    send_request(make_req(REQ_SORT, 0, 0));
    send_request(make_req(REQ_INSERT, 3, 1));
    send_request(make_req(REQ_INSERT, 5, 0));
    send_request(make_req(REQ_PUSH_BACK, 32'sh7fffffff, 0));
    send_request(make_req(REQ_PUSH_FRONT, 32'sh80000000, 31));
    send_request(make_req(REQ_PUSH_BACK, -1, 16));
    send_request(make_req(REQ_INSERT, 0, 4));
    send_request(make_req(REQ_INSERT, 7, 2));
    send_request(make_req(REQ_INSERT, 9, 31));
    send_request(make_req(REQ_FIND, 32'sh7fffffff, 0));
    send_request(make_req(REQ_FIND, 12345, 0));
    send_request(make_req(REQ_READ, 0, 0));
    send_request(make_req(REQ_READ, 0, 5));
    send_request(make_req(REQ_READ, 0, 6));
    send_request(make_req(REQ_READ, 0, 31));
    send_request(make_req(REQ_SORT, 0, 0));
    send_request(make_req(REQ_READ, 0, 0));
    send_request(make_req(REQ_READ, 0, 5));
    send_request(make_req(REQ_POP_BACK, 0, 0));
    send_request(make_req(REQ_POP_FRONT, 0, 0));
    send_request(make_req(REQ_SORT, 0, 0));
    wait_drained();

    random_phase(480);
    wait_drained();

    in_idle_pct = 88;
    out_idle_pct = 18;
    random_phase(480);
    wait_drained();

    in_idle_pct = 0;
    out_idle_pct = 0;
    hold_len = 300;
    random_phase(480);
    wait_drained();

    repeat (CAPACITY + 8) @(posedge clk);
    if (sb.mismatches == 0 && sb.pending_results.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end
endmodule
